### hw/rtl/absep_pkg.sv
// shared types and constants of the acknowledged byte-stream endpoint
package absep_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int MAX_PAYLOAD  = 32;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_READ   = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_FLUSH  = 3'd3,
		CMD_RXHDR  = 3'd4,
		CMD_RXBYTE = 3'd5,
		CMD_TICK   = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LOCAL   = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_RSVD    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLY,
		ST_HEADER,
		ST_PAYLOAD
	} state_t;

	localparam logic [1:0] REG_AUTOFLUSH = 2'd0;
	localparam logic [1:0] REG_OWN_ADDR  = 2'd1;
	localparam logic [1:0] REG_STREAM    = 2'd2;

	// input item
	typedef struct packed {
		logic [5:0] rx_payload_count;
		logic [7:0] rx_peer_id;
		logic [7:0] rx_ack_id;
		logic [6:0] rx_ack_bytes;
		logic [7:0] rx_register;
		logic [7:0] rx_dest_addr;
		logic [7:0] data_byte;
	} in_item_t;

	// controller to datapath
	typedef struct packed {
		logic exec;       // apply the accepted item to the state
		logic start_pkt;  // reset payload index and tick count
		logic next_byte;  // step the payload read index
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic send;       // item causes a packet
		logic more;       // payload bytes remain after the current one
		logic has_pay;    // packet has any payload
	} dp_sts_t;

endpackage

### hw/rtl/ack_byte_stream_endpoint.sv
// top level of the acknowledged byte-stream endpoint
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser command, tdata: item fields
//  m_axis    out  tvalid/tready          tdata, tuser kind, tlast
//  cfg       in   cfg_we                 cfg_index, cfg_wdata
// each item passes an accept state and a local reply state; a packet
// then adds a header state and a payload state for its bytes, read
// from the send ring ram. reset clears all control state, the rings
// hold undefined data. an output stall holds the sequencer in place.
module ack_byte_stream_endpoint (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0]
	input  logic [2:0]  s_axis_tuser,
	// data_byte[7:0] rx_dest_addr[15:8] rx_register[23:16]
	// rx_ack_bytes[30:24] rx_ack_id[38:31] rx_peer_id[46:39]
	// rx_payload_count[52:47] zero[55:53]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// data_byte_res[7:0] valid_res[8] stored_count[15:9] tx_ack_bytes[22:16]
	// tx_ack_id[30:23] tx_send_id[38:31] tx_payload_len[44:39] zero[47:45]
	output logic [47:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import absep_pkg::*;

	logic [15:0] autoflush_q;
	logic [7:0]  own_addr_q, stream_q;
	in_item_t    item_in;
	dp_cmd_t     dcmd;
	dp_sts_t     dsts;
	logic        in_fire, out_load, out_last, out_busy;
	kind_t       out_kind;
	logic [7:0]  reply_byte, pay_byte, ack_id, send_id;
	logic        reply_valid;
	logic [6:0]  recv_count, ack_bytes;
	logic [5:0]  pkt_len;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_busy = m_axis_tvalid && !m_axis_tready;

	// the item is applied at the edge that accepts the transfer
	assign item_in = s_axis_tdata[52:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			autoflush_q <= '0;
			own_addr_q  <= '0;
			stream_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AUTOFLUSH: autoflush_q <= cfg_wdata;
				REG_OWN_ADDR:  own_addr_q  <= cfg_wdata[7:0];
				REG_STREAM:    stream_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	absep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (out_busy),
		.sts      (dsts),
		.cmd      (dcmd),
		.in_ready (s_axis_tready),
		.out_load (out_load),
		.out_kind (out_kind),
		.out_last (out_last)
	);

	absep_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (s_axis_tuser),
		.item        (item_in),
		.cmd         (dcmd),
		.autoflush_q (autoflush_q),
		.own_addr_q  (own_addr_q),
		.stream_q    (stream_q),
		.sts         (dsts),
		.reply_byte  (reply_byte),
		.reply_valid (reply_valid),
		.pay_byte    (pay_byte),
		.recv_count  (recv_count),
		.ack_bytes   (ack_bytes),
		.ack_id      (ack_id),
		.send_id     (send_id),
		.pkt_len     (pkt_len)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tuser <= out_kind;
			m_axis_tlast <= out_last;
			unique case (out_kind)
				KIND_HEADER:  m_axis_tdata <= {3'b0, pkt_len, send_id, ack_id, ack_bytes,
						recv_count, 1'b0, 8'd0};
				KIND_PAYLOAD: m_axis_tdata <= {3'b0, 6'd0, 8'd0, 8'd0, 7'd0,
						recv_count, 1'b0, pay_byte};
				default:      m_axis_tdata <= {3'b0, 6'd0, 8'd0, 8'd0, 7'd0,
						recv_count, reply_valid, reply_byte};
			endcase
		end
	end
endmodule

### hw/rtl/absep_ram.sv
// generic single-port-write ram with registered read
module absep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/absep_ctrl.sv
// controller state machine of the endpoint
module absep_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_busy,
	input  absep_pkg::dp_sts_t  sts,
	output absep_pkg::dp_cmd_t  cmd,
	output logic                in_ready,
	output logic                out_load,
	output absep_pkg::kind_t    out_kind,
	output logic                out_last
);
	import absep_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_fire) state_d = ST_REPLY;
			ST_REPLY:   if (!out_busy) state_d = sts.send ? ST_HEADER : ST_IDLE;
			ST_HEADER:  if (!out_busy) state_d = sts.has_pay ? ST_PAYLOAD : ST_IDLE;
			ST_PAYLOAD: if (!out_busy && !sts.more) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		out_kind = KIND_LOCAL;
		out_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_fire;
			end
			ST_REPLY: begin
				out_load      = !out_busy;
				out_last      = !sts.send;
				cmd.start_pkt = !out_busy && sts.send;
			end
			ST_HEADER: begin
				out_load      = !out_busy;
				out_kind      = KIND_HEADER;
				out_last      = !sts.has_pay;
			end
			ST_PAYLOAD: begin
				out_load      = !out_busy;
				out_kind      = KIND_PAYLOAD;
				out_last      = !sts.more;
				cmd.next_byte = !out_busy;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### hw/rtl/absep_dp.sv
// datapath of the endpoint: rings, counters, acknowledge logic
module absep_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          command,
	input  absep_pkg::in_item_t item,
	input  absep_pkg::dp_cmd_t  cmd,
	input  logic [15:0]         autoflush_q,
	input  logic [7:0]          own_addr_q,
	input  logic [7:0]          stream_q,
	output absep_pkg::dp_sts_t  sts,
	output logic [7:0]          reply_byte,
	output logic                reply_valid,
	output logic [7:0]          pay_byte,
	output logic [6:0]          recv_count,
	output logic [6:0]          ack_bytes,
	output logic [7:0]          ack_id,
	output logic [7:0]          send_id,
	output logic [5:0]          pkt_len
);
	import absep_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int PW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [CW-1:0] BUF_N = CW'(BUFFER_BYTES);
	localparam logic [CW-1:0] MAX_N = CW'(MAX_PAYLOAD);

	logic [AW-1:0] send_head_q, recv_head_q;
	logic [CW-1:0] send_count_q, recv_count_q;
	logic [7:0]    out_id_q, id_ctr_q, ack_id_q, peer_q;
	logic [PW-1:0] plen_q, acc_rem_q, pidx_q;
	logic [CW-1:0] ackb_q;
	logic [15:0]   ticks_q;
	logic          send_q, valid_q, rd_ok_q, fresh_q;
	logic [7:0]    rbyte_q;

	logic [7:0]    next_id;
	logic          hdr_ok, ack_match, s_we, r_we;
	logic [CW-1:0] ackb, rem_cnt, space, take;
	logic [6:0]    cnt_ext;
	logic [7:0]    recv_rd;

	cmd_t c;
	assign c = cmd_t'(command);

	// fresh nonzero packet id
	assign next_id = (id_ctr_q == 8'hFF) ? 8'd1 : id_ctr_q + 8'd1;

	// header checks
	assign hdr_ok    = item.rx_dest_addr == own_addr_q && item.rx_register == stream_q;
	assign ack_match = item.rx_ack_id == out_id_q;

	// acknowledged byte count, nothing when idle, clamped to the queued bytes
	always_comb begin
		ackb = (out_id_q == 8'd0) ? '0 : CW'(item.rx_ack_bytes);
		if (ackb > send_count_q)
			ackb = send_count_q;
	end
	assign rem_cnt = send_count_q - ackb;
	assign space   = BUF_N - recv_count_q;
	assign cnt_ext = 7'(item.rx_payload_count);
	assign take    = (7'(cnt_ext) > 7'(space)) ? space : CW'(cnt_ext);

	// send ring write on accepted write command, receive ring write on accepted rx byte
	assign s_we = cmd.exec && c == CMD_WRITE && send_count_q < BUF_N;
	assign r_we = cmd.exec && c == CMD_RXBYTE && acc_rem_q != '0 && recv_count_q < BUF_N;

	// payload read address runs one byte ahead only when the current byte leaves
	absep_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_send_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (AW'(send_head_q + AW'(send_count_q))),
		.wdata (item.data_byte),
		.raddr (AW'(send_head_q + AW'(pidx_q) + AW'(cmd.next_byte))),
		.rdata (pay_byte)
	);

	absep_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_recv_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (AW'(recv_head_q + AW'(recv_count_q))),
		.wdata (item.data_byte),
		.raddr (recv_head_q),
		.rdata (recv_rd)
	);

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_head_q  <= '0;
			send_count_q <= '0;
			out_id_q     <= '0;
			id_ctr_q     <= '0;
			plen_q       <= '0;
			ackb_q       <= '0;
			ack_id_q     <= '0;
			peer_q       <= '0;
			recv_head_q  <= '0;
			recv_count_q <= '0;
			acc_rem_q    <= '0;
			ticks_q      <= '0;
			send_q       <= 1'b0;
			valid_q      <= 1'b0;
			rd_ok_q      <= 1'b0;
			fresh_q      <= 1'b0;
			rbyte_q      <= '0;
			pidx_q       <= '0;
		end else begin
			// hold the read byte while the reply waits
			fresh_q <= cmd.exec;
			if (fresh_q) begin
				rbyte_q <= recv_rd;
			end
			if (cmd.start_pkt) begin
				ticks_q <= '0;
				pidx_q  <= '0;
			end
			if (cmd.next_byte) begin
				pidx_q <= pidx_q + 1'b1;
			end
			if (cmd.exec) begin
				send_q  <= 1'b0;
				valid_q <= 1'b0;
				rd_ok_q <= 1'b0;
				unique case (c) inside
					CMD_WRITE: begin
						if (send_count_q < BUF_N) begin
							send_count_q <= send_count_q + 1'b1;
							valid_q      <= 1'b1;
							if ((send_count_q + 1'b1 >= MAX_N ||
									(autoflush_q != '0 && ticks_q > autoflush_q))
									&& out_id_q == 8'd0) begin
								out_id_q <= next_id;
								id_ctr_q <= next_id;
								plen_q   <= PW'((send_count_q + 1'b1 > MAX_N) ? MAX_N
										: send_count_q + 1'b1);
								send_q   <= 1'b1;
							end
						end
					end
					CMD_READ, CMD_PEEK: begin
						if (recv_count_q != '0) begin
							valid_q <= 1'b1;
							rd_ok_q <= 1'b1;
							if (c == CMD_READ) begin
								recv_head_q  <= recv_head_q + 1'b1;
								recv_count_q <= recv_count_q - 1'b1;
							end
						end
					end
					CMD_FLUSH: begin
						if (out_id_q == 8'd0 && send_count_q != '0) begin
							out_id_q <= next_id;
							id_ctr_q <= next_id;
							plen_q   <= PW'((send_count_q > MAX_N) ? MAX_N : send_count_q);
							send_q   <= 1'b1;
							valid_q  <= 1'b1;
						end
					end
					CMD_RXHDR: begin
						acc_rem_q <= '0;
						if (hdr_ok) begin
							valid_q <= 1'b1;
							if (ack_match) begin
								send_head_q  <= AW'(send_head_q + AW'(ackb));
								send_count_q <= rem_cnt;
								if (rem_cnt != '0) begin
									out_id_q <= next_id;
									id_ctr_q <= next_id;
									plen_q   <= PW'((rem_cnt > MAX_N) ? MAX_N : rem_cnt);
									send_q   <= 1'b1;
								end else begin
									out_id_q <= '0;
									plen_q   <= '0;
								end
							end else begin
								send_q <= 1'b1;
							end
							if (item.rx_peer_id != 8'd0) begin
								if (item.rx_peer_id != peer_q) begin
									peer_q    <= item.rx_peer_id;
									ackb_q    <= take;
									ack_id_q  <= item.rx_peer_id;
									acc_rem_q <= PW'(take);
								end
								send_q <= 1'b1;
							end
						end
					end
					CMD_RXBYTE: begin
						if (r_we) begin
							recv_count_q <= recv_count_q + 1'b1;
							acc_rem_q    <= acc_rem_q - 1'b1;
							valid_q      <= 1'b1;
						end
					end
					CMD_TICK: begin
						if (ticks_q != 16'hFFFF) ticks_q <= ticks_q + 1'b1;
						valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// status and result fields
	assign sts.send    = send_q;
	assign sts.has_pay = plen_q != '0;
	assign sts.more    = (pidx_q + 1'b1) < plen_q;
	assign reply_valid = valid_q;
	assign reply_byte  = rd_ok_q ? (fresh_q ? recv_rd : rbyte_q) : 8'd0;
	assign recv_count  = 7'(recv_count_q);
	assign ack_bytes   = 7'(ackb_q);
	assign ack_id      = ack_id_q;
	assign send_id     = out_id_q;
	assign pkt_len     = 6'(plen_q);
endmodule
